@@ src/mwd_pkg.sv @@
// ============================================================================
// mwd_pkg: shared types and constants for the multiword-by-word divider
// Request and result payloads, word width and the serial unit's status.
// ============================================================================
`default_nettype none

package mwd_pkg;

    // Word width of the dividend digits, divisor and results
    localparam int WORD_W = 32;
    // Step counter width for one word of radix-2 steps
    localparam int CNT_W  = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

    typedef struct packed {
        logic [WORD_W-1:0] digit;
        logic              first_digit;
        logic              last_digit;
    } mwd_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] quotient_digit;
        logic [WORD_W-1:0] remainder_out;
        logic              drop_leading;
        logic              last_result;
    } mwd_out_t;

    // Status of the bit-serial division unit
    typedef struct packed {
        logic busy;
        logic done;
    } mwd_status_t;

endpackage

`default_nettype wire

@@ src/mwd_serial_div.sv @@
// ============================================================================
// mwd_serial_div: bit-serial restoring division of one word
// Shifts the dividend word out MSB first into the running remainder and
// shifts one quotient bit in per cycle. The remainder stays for the next word.
// ============================================================================
`default_nettype none

module mwd_serial_div
    import mwd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic              start_first,
    input  wire logic [WORD_W-1:0] start_digit,
    input  wire logic [WORD_W-1:0] divisor,
    output mwd_status_t            status,
    output logic      [WORD_W-1:0] quotient,
    output logic      [WORD_W-1:0] remainder
);

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W+1:0] trial;
    logic              qbit;

    // Trial subtract of the divisor from {0, remainder, next dividend bit}
    always_comb begin
        shifted  = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
        trial    = {1'b0, rem_reg, quo_reg[WORD_W-1]} - {2'b00, divisor};
        qbit     = ~trial[WORD_W+1];
        rem_next = qbit ? trial[WORD_W-1:0] : shifted;
    end

    // Hold the partial remainder and step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (start_first) begin
                    rem_reg <= '0;
                end
                cnt_reg  <= LAST_STEP;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift dividend bits out and quotient bits in
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= start_digit;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[WORD_W-2:0], qbit};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

`default_nettype wire

@@ src/multiword_by_word_divider_top.sv @@
// A new request is taken only in the idle state, once the previous division has finished
// and its result is in the output register. The single radix-2 restoring unit produces
// one quotient bit per cycle and the remainder chains between words.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, aresetn low): divisor = 1, partial remainder = 0, channels empty.
// ============================================================================
// multiword_by_word_divider_top: multiword unsigned number by one-word divisor
// Accepts dividend words most significant first and returns one quotient
// word and the running remainder per word.
// ============================================================================
`default_nettype none

module multiword_by_word_divider_top
    import mwd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mwd_in_t           s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mwd_out_t               m_data,
    input  wire logic              cfg_we,
    input  wire logic [WORD_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t            state_reg;
    logic [WORD_W-1:0] divisor_reg;
    logic              drop_reg;
    logic              last_reg;
    logic              m_valid_reg;
    mwd_out_t          m_data_reg;
    mwd_status_t       unit_status;
    logic [WORD_W-1:0] unit_quo;
    logic [WORD_W-1:0] unit_rem;
    logic              accept;
    logic              out_free;
    logic              load_out;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = out_free &&
                      ((state_reg == ST_HOLD) || (state_reg == ST_RUN && unit_status.done));

    // Divisor register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= WORD_W'(1);
        end else if (cfg_we) begin
            divisor_reg <= cfg_wdata;
        end
    end

    mwd_serial_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (accept),
        .start_first (s_data.first_digit),
        .start_digit (s_data.digit),
        .divisor     (divisor_reg),
        .status      (unit_status),
        .quotient    (unit_quo),
        .remainder   (unit_rem)
    );

    // Sequence requests and hold the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        drop_reg  <= s_data.first_digit && !s_data.last_digit &&
                                     (s_data.digit < divisor_reg);
                        last_reg  <= s_data.last_digit;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (unit_status.done) begin
                        state_reg <= out_free ? ST_IDLE : ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (load_out) begin
                m_data_reg.quotient_digit <= unit_quo;
                m_data_reg.remainder_out  <= unit_rem;
                m_data_reg.drop_leading   <= drop_reg;
                m_data_reg.last_result    <= last_reg;
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The unit is never busy while a new request can be taken
    a_ready_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !unit_status.busy)
        else $error("request taken while division unit busy");

    // An accepted request starts the unit on the next cycle
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> unit_status.busy)
        else $error("division unit did not start");

    // Completion is only reported while a request is in flight
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_status.done |-> state_reg == ST_RUN)
        else $error("division done outside run state");

    // A new result appears only after a division finished
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) != ST_IDLE)
        else $error("result loaded without a finished division");

endmodule

`default_nettype wire

@@ test/tb_multiword_by_word_divider_top.sv @@
// ============================================================================
// tb_multiword_by_word_divider_top: self-checking bench for the divider
// Sends dividend words over the request channel and predicts each quotient
// word, remainder, leading-zero flag and last mark with a bit-serial restoring
// division in the bench. Covers the reset divisor, extreme words and divisors,
// one-word numbers, a zero divisor, a divisor change inside a number, output
// back-pressure and random multiword numbers under random idling.
// ============================================================================
`default_nettype none

module tb_multiword_by_word_divider_top
    import mwd_pkg::*;
();

    localparam int TARGET_WORDS = 1850;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    mwd_in_t           s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    mwd_out_t          m_data;
    logic              cfg_we    = 1'b0;
    logic [WORD_W-1:0] cfg_wdata = '0;

    // Bench-side copy of the divider state
    logic [WORD_W-1:0] model_divisor   = 1;
    logic [WORD_W-1:0] model_remainder = '0;
    mwd_out_t          pending_quotients[$];

    int  error_count   = 0;
    int  words_sent    = 0;
    int  hold_off_left = 0;
    bit  sender_gaps   = 1'b0;
    bit  receiver_gaps = 1'b0;

    multiword_by_word_divider_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop on a hung run
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Restoring division of {remainder, word} by the divisor, one bit per step
    function automatic mwd_out_t divide_word(mwd_in_t req, logic [WORD_W-1:0] div,
                                             logic [WORD_W-1:0] held_rem);
        mwd_out_t          res;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic              carry;
        rem = req.first_digit ? '0 : held_rem;
        quo = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            carry = rem[WORD_W-1];
            rem   = {rem[WORD_W-2:0], req.digit[k]};
            quo   = {quo[WORD_W-2:0], 1'b0};
            // a carry-out forces the subtraction
            if (carry || rem >= div) begin
                rem    = rem - div;
                quo[0] = 1'b1;
            end
        end
        res.quotient_digit = quo;
        res.remainder_out  = rem;
        res.drop_leading   = req.first_digit && !req.last_digit && (req.digit < div);
        res.last_result    = req.last_digit;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        error_count++;
        if (error_count <= 40) begin
            $display("ERROR @%0t %s: got %h expected %h", $realtime, what, got, want);
        end
    endtask

    // Predict on each accepted request, check each accepted result
    always @(posedge aclk) begin : result_check
        mwd_out_t want;
        if (!aresetn) begin
            model_divisor   = 1;
            model_remainder = '0;
            pending_quotients.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_quotients.size() == 0) begin
                    report_mismatch("result with nothing pending", m_data.quotient_digit, '0);
                end else begin
                    want = pending_quotients.pop_front();
                    if (m_data.quotient_digit !== want.quotient_digit)
                        report_mismatch("quotient_digit", m_data.quotient_digit,
                                        want.quotient_digit);
                    if (m_data.remainder_out !== want.remainder_out)
                        report_mismatch("remainder_out", m_data.remainder_out,
                                        want.remainder_out);
                    if (m_data.drop_leading !== want.drop_leading)
                        report_mismatch("drop_leading", WORD_W'(m_data.drop_leading),
                                        WORD_W'(want.drop_leading));
                    if (m_data.last_result !== want.last_result)
                        report_mismatch("last_result", WORD_W'(m_data.last_result),
                                        WORD_W'(want.last_result));
                end
            end
            if (s_valid && s_ready) begin
                want = divide_word(s_data, model_divisor, model_remainder);
                model_remainder = want.remainder_out;
                pending_quotients.push_back(want);
            end
            if (cfg_we) begin
                model_divisor = cfg_wdata;
            end
        end
    end

    // Result-side ready: long hold-off when asked, else random or always ready
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            m_ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else if (receiver_gaps) begin
            m_ready <= ($urandom_range(99) >= 27);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one request and hold it until accepted; called and returns at a falling edge
    task automatic send_word(logic [WORD_W-1:0] digit, bit first, bit last);
        mwd_in_t req;
        req.digit       = digit;
        req.first_digit = first;
        req.last_digit  = last;
        if (sender_gaps && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_quotients.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_divisor(logic [WORD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // Word picker biased toward the edges around the divisor
    function automatic logic [WORD_W-1:0] pick_word(logic [WORD_W-1:0] div);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return div - 1;
            3:       return div;
            4:       return div + 1;
            5:       return WORD_W'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_divisor(int phase);
        case (phase % 8)
            0:       return 1;
            1:       return '1;
            2:       return 2;
            3:       return WORD_W'(1) << $urandom_range(WORD_W - 1);
            4:       return WORD_W'($urandom_range(1, 255));
            5:       return (WORD_W'($urandom) >> 1) | (WORD_W'(1) << (WORD_W - 1));
            default: return ($urandom | 1);
        endcase
    endfunction

    // Reset divisor of one, with and without a first mark
    task automatic test_reset_divisor();
        send_word('0, 1'b0, 1'b0);
        send_word(32'h8000_0001, 1'b0, 1'b0);
        send_word('1, 1'b1, 1'b1);
        send_word('1, 1'b1, 1'b0);
        send_word(32'h1234_5678, 1'b0, 1'b1);
        wait_drained();
    endtask

    // Largest divisor, leading-zero flag and one-word numbers
    task automatic test_extremes();
        write_divisor('1);
        send_word(32'hFFFF_FFFE, 1'b1, 1'b0);
        send_word('1, 1'b0, 1'b0);
        send_word('0, 1'b0, 1'b1);
        send_word('1, 1'b1, 1'b0);
        send_word('0, 1'b1, 1'b1);
        send_word('1, 1'b1, 1'b1);
        wait_drained();
        write_divisor(32'h0000_0003);
        send_word(32'h0000_0002, 1'b1, 1'b1);
        send_word(32'h0000_0002, 1'b1, 1'b0);
        send_word('1, 1'b0, 1'b1);
        wait_drained();
    endtask

    // Zero divisor, then a divisor change inside a number leaves a big remainder
    task automatic test_zero_and_mid_change();
        write_divisor('0);
        send_word(32'hDEAD_BEEF, 1'b1, 1'b0);
        send_word(32'hFFFF_0000, 1'b0, 1'b0);
        wait_drained();
        write_divisor(32'h0000_0007);
        send_word(32'h0F0F_0F0F, 1'b0, 1'b0);
        send_word('1, 1'b0, 1'b1);
        wait_drained();
    endtask

    // Hold results off long enough for the block to stall its input
    task automatic test_output_hold_off();
        write_divisor(32'h0001_0003);
        hold_off_left = 400;
        send_word($urandom, 1'b1, 1'b0);
        for (int i = 0; i < 6; i++) begin
            send_word($urandom, 1'b0, i == 5);
        end
        wait_drained();
    endtask

    // Random multiword numbers over a series of divisors
    task automatic test_random_numbers();
        int                phase;
        int                len;
        logic [WORD_W-1:0] div;
        phase = 0;
        while (words_sent < TARGET_WORDS) begin
            div = pick_divisor(phase);
            write_divisor(div);
            // phase 3 runs with no idling on either side
            sender_gaps   = (phase != 3);
            receiver_gaps = (phase != 3);
            for (int n = 0; n < ((phase == 3) ? 60 : 25); n++) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
                for (int w = 0; w < len; w++) begin
                    // mostly well-formed marks, some stray ones
                    if ($urandom_range(99) < 10)
                        send_word(pick_word(div), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                    else
                        send_word(pick_word(div), w == 0, w == len - 1);
                end
                // sender pauses until all results are back
                if ($urandom_range(19) == 0) wait_drained();
            end
            wait_drained();
            phase++;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        test_reset_divisor();
        test_extremes();
        test_zero_and_mid_change();
        test_output_hold_off();
        test_random_numbers();

        wait_drained();
        repeat (40) @(negedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ multiword_by_word_divider_top.f @@
src/mwd_pkg.sv
src/mwd_serial_div.sv
src/multiword_by_word_divider_top.sv
test/tb_multiword_by_word_divider_top.sv
